// File: hdl/f2h_pkg.sv
`timescale 1ns / 1ps
package f2h_pkg;
	localparam logic [30:0] ExpAll    = 31'h7f800000;
	localparam logic [30:0] OvfLimit  = 31'h47800000;
	localparam logic [30:0] NormLimit = 31'h38800000;
	localparam logic [31:0] RebiasAdd = 32'hc8000000;
	localparam logic [31:0] RoundHalf = 32'h00000fff;
	localparam logic [7:0]  DenormBase = 8'd113;
	localparam logic [14:0] Inf16     = 15'h7c00;
	localparam logic [14:0] QNan16    = 15'h7e00;

	function automatic logic [14:0] rne13(input logic [31:0] v);
		logic [31:0] s;
		s = v + RoundHalf + {31'd0, v[13]};
		return s[27:13];
	endfunction
endpackage

// File: hdl/float32_to_float16_convert.sv
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the receiver takes results; a stalled
// output (out_ready low) holds the input register and drops in_ready.
// Reset (arst_n low, asynchronous) empties both stages; payload is not reset.
module float32_to_float16_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] float_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] half_bits
);
	logic        v_s1;
	logic [31:0] bits_s1;
	logic        adv_s2;
	logic        adv_s1;
	logic [30:0] mag;
	logic [14:0] res;
	logic [23:0] sig;
	logic [7:0]  sh;
	logic [23:0] shifted;

	assign adv_s2   = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv_s2;
	assign adv_s1   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv_s2) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) bits_s1 <= float_bits;
		if (adv_s2) half_bits <= {bits_s1[31], res};
	end

	always_comb begin
		mag = bits_s1[30:0];
		sig = {1'b1, mag[22:0]};
		sh = f2h_pkg::DenormBase - mag[30:23];
		shifted = (sh < 8'd24) ? (sig >> sh[4:0]) : 24'd0;
		if (mag > f2h_pkg::ExpAll) res = f2h_pkg::QNan16;
		else if (mag >= f2h_pkg::OvfLimit) res = f2h_pkg::Inf16;
		else if (mag < f2h_pkg::NormLimit) res = f2h_pkg::rne13({8'd0, shifted});
		else res = f2h_pkg::rne13({1'b0, mag} + f2h_pkg::RebiasAdd);
	end
endmodule

// File: hdl/f2h_checker.sv
`timescale 1ns / 1ps
module f2h_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] float_bits,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] half_bits
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(half_bits))
		else $error("result item changed while stalled");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |=> ##1 out_valid)
		else $error("accepted item produced no result");
	// With the output empty at acceptance and taken on the next cycle, the item
	// passes the input register without a stall and reaches the result register.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid ##1 out_ready
		|=> half_bits[15] == $past(float_bits[31], 2))
		else $error("sign not carried");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
endmodule

bind float32_to_float16_convert f2h_checker u_f2h_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] float_bits;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] half_bits;

	logic [15:0] half_queue[$];
	int          mismatches;
	int          cycle_count;
	bit          hold_output;
	bit          stall_enable;

	typedef struct {
		logic [31:0] value;
		logic [15:0] half;
		bit          known;
	} float_row_t;

	float_row_t float_rows[$];

	float32_to_float16_convert i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.float_bits (float_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.half_bits  (half_bits)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [15:0] narrow_half(input logic [31:0] bits);
		logic [15:0] sgn;
		logic [31:0] mag;
		logic [31:0] sig;
		logic [31:0] rounded;
		logic [31:0] shifted;
		int          shift;
		sgn = {bits[31], 15'd0};
		mag = {1'b0, bits[30:0]};
		shifted = 32'd0;
		if (mag >= 32'h7f800000) begin
			return (mag > 32'h7f800000) ? (sgn | 16'h7e00) : (sgn | 16'h7c00);
		end
		if (mag >= 32'h47800000)
			return sgn | 16'h7c00;
		if (mag < 32'h38800000) begin
			sig = {8'd0, 1'b1, mag[22:0]};
			shift = 113 - int'(mag[30:23]);
			if (shift < 24)
				shifted = sig >> shift;
		end else begin
			shifted = mag + 32'hc8000000;
		end
		rounded = (shifted + 32'h00000fff + {31'd0, shifted[13]}) >> 13;
		return sgn | rounded[15:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic add_row(input logic [31:0] v, input logic [15:0] h, input bit k);
		float_row_t r;
		r.value = v;
		r.half = h;
		r.known = k;
		float_rows.push_back(r);
	endtask

	// Offer one item, optionally after an idle burst, and wait for acceptance.
	// Valid is left high so that the next item can follow without a gap.
	task automatic send_float(input logic [31:0] v, input bit allow_idle);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		float_bits <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		half_queue.push_back(narrow_half(v));
	endtask

	function automatic logic [31:0] random_float();
		logic [31:0] v;
		int          pick;
		v = $urandom;
		pick = $urandom_range(0, 9);
		case (pick)
			0: v[30:23] = 8'hff;
			1: v[30:23] = 8'h00;
			2: v[30:23] = 8'($urandom_range(90, 112));
			3: v[30:23] = 8'($urandom_range(140, 143));
			4: v[30:23] = 8'($urandom_range(103, 142));
			5: v[30:23] = 8'($urandom_range(100, 145));
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0)
			v[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0fff;
		return v;
	endfunction

	// Receiver: random stall bursts, plus a long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_output)
				out_ready <= 1'b0;
			else if (stall_enable && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (half_queue.size() == 0)
				report_mismatch("unexpected result", half_bits, 16'h0);
			else begin
				if (half_bits !== half_queue[0])
					report_mismatch("half_bits", half_bits, half_queue[0]);
				void'(half_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		float_bits = 32'h0;
		mismatches = 0;
		cycle_count = 0;
		hold_output = 1'b0;
		stall_enable = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(32'h00000000, 16'h0000, 1);
		add_row(32'h80000000, 16'h8000, 1);
		add_row(32'h7f800000, 16'h7c00, 1);
		add_row(32'hff800000, 16'hfc00, 1);
		add_row(32'h7f800001, 16'h7e00, 1);
		add_row(32'hffffffff, 16'hfe00, 1);
		add_row(32'h3f800000, 16'h3c00, 1);
		add_row(32'h47800000, 16'h7c00, 1);
		add_row(32'hc7800000, 16'hfc00, 1);
		add_row(32'h477ff000, 16'h7c00, 1);
		add_row(32'h477fefff, 16'h7bff, 1);
		add_row(32'h38800000, 16'h0400, 1);
		add_row(32'h387fffff, 16'h0000, 0);
		add_row(32'h33800000, 16'h0000, 0);
		add_row(32'h33000000, 16'h0000, 0);
		add_row(32'h00000001, 16'h0000, 0);
		add_row(32'h007fffff, 16'h0000, 0);
		add_row(32'h3f801000, 16'h0000, 0);
		add_row(32'h3f803000, 16'h0000, 0);
		add_row(32'h7f7fffff, 16'h7c00, 1);
		add_row(32'h55555555, 16'h7c00, 1);
		add_row(32'haaaaaaaa, 16'h0000, 0);

		foreach (float_rows[i]) begin
			if (float_rows[i].known) begin
				want = narrow_half(float_rows[i].value);
				if (want !== float_rows[i].half)
					report_mismatch("table entry", want, float_rows[i].half);
			end
			send_float(float_rows[i].value, 1);
		end

		// Long receiver hold-off while items keep coming, so the input stalls.
		fork
			begin
				hold_output = 1'b1;
				repeat (40) @(posedge clk);
				hold_output = 1'b0;
			end
			repeat (8) send_float(random_float(), 0);
		join

		for (int n = 0; n < 1800; n++) begin
			if (n == 900) begin
				// Sender pause until the pipeline has drained.
				in_valid <= 1'b0;
				while (half_queue.size() != 0)
					@(posedge clk);
			end
			if (n == 1500)
				stall_enable = 1'b0;
			send_float(random_float(), n < 1500);
		end
		in_valid <= 1'b0;

		while (half_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
